/* hw/rtl/errt_pkg.sv */
// ----------------------------------------------------------------------------
// errt_pkg
// Shared constants, codes and control types of the echo reply rtt tracker.
// ----------------------------------------------------------------------------
package errt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int SEC_W  = 32;
    localparam int USEC_W = 20;
    localparam int ENTRY_W = SEC_W + USEC_W;

    localparam int USEC_PER_SEC = 1000000;
    localparam int MS_PER_SEC   = 1000;
    localparam int USEC_PER_MS  = 1000;

    // reciprocal of USEC_PER_MS, exact for magnitudes below 2**21
    localparam int DIV_SHIFT = 30;
    localparam longint DIV_MUL = ((64'd1 << DIV_SHIFT) + USEC_PER_MS - 1) / USEC_PER_MS;

    localparam int MIN_ICMP_LEN = 8;
    localparam logic [7:0]  ECHO_REPLY_TYPE = 8'd0;
    localparam logic [15:0] RCV_MAX         = 16'hffff;
    localparam logic [31:0] RTT_MAX         = 32'hffff_ffff;

    typedef enum logic [2:0] {
        ST_SENT      = 3'd0,
        ST_FULL      = 3'd1,
        ST_SHORT     = 3'd2,
        ST_NOT_OURS  = 3'd3,
        ST_SEQ_RANGE = 3'd4,
        ST_ACCEPTED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_SUM
    } t_state;

    typedef struct packed {
        logic load;
        logic diff;
        logic mul;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

/* hw/rtl/errt_ctrl.sv */
// ----------------------------------------------------------------------------
// errt_ctrl
// Sequencer: accepts a word, steps the datapath through difference, multiply
// and sum, then hands the result to the output register.
// ----------------------------------------------------------------------------
module errt_ctrl
    import errt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = S_MUL;
            S_MUL:  n_state = S_SUM;
            S_SUM: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIFF: o_cmd.diff = 1'b1;
            S_MUL:  o_cmd.mul  = 1'b1;
            S_SUM:  o_cmd.out_load = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/errt_dp.sv */
// ----------------------------------------------------------------------------
// errt_dp
// Datapath: timestamp table, counters, reply checks, rtt arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module errt_dp
    import errt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_sts       o_sts,
    input  logic          i_cfg_valid,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_action,
    input  logic [31:0]   i_time_sec,
    input  logic [19:0]   i_time_usec,
    input  logic [3:0]    i_ip_header_words,
    input  logic [15:0]   i_packet_length,
    input  logic [7:0]    i_icmp_type,
    input  logic [15:0]   i_icmp_ident,
    input  logic [15:0]   i_icmp_seq,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [2:0]    o_status,
    output logic [15:0]   o_seq_number,
    output logic [31:0]   o_rtt_ms,
    output logic [15:0]   o_icmp_length,
    output logic [6:0]    o_sent_total,
    output logic [15:0]   o_received_total
);

    // configuration and counters
    logic [15:0]       r_echo_ident;
    logic [CNT_W-1:0]  r_send_cnt;
    logic [15:0]       r_rcv_cnt;

    // timestamp table
    logic [ENTRY_W-1:0]     r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_vld;
    logic [ENTRY_W-1:0]     r_rd_data;
    logic                   r_rd_vld;

    // item registers
    t_status     r_status;
    logic [15:0] r_seq;
    logic [15:0] r_ilen;
    logic [31:0] r_tsec;
    logic [19:0] r_tusec;

    // arithmetic stages
    logic signed [32:0] r_ds;
    logic signed [21:0] r_du;
    logic signed [42:0] r_ms_s;
    logic [41:0]        r_q;
    logic               r_du_neg;

    // output register
    logic        r_out_valid;
    t_status     r_out_status;
    logic [15:0] r_out_seq;
    logic [31:0] r_out_rtt;
    logic [15:0] r_out_ilen;
    logic [6:0]  r_out_sent;
    logic [15:0] r_out_rcvd;

    logic [5:0]         n_hlen;
    logic [15:0]        n_ilen;
    t_status            n_status;
    logic               n_full;
    logic [SLOT_W-1:0]  n_addr;
    logic               n_wr;
    logic [ENTRY_W-1:0] n_entry;
    logic signed [32:0] n_ds;
    logic signed [21:0] n_du;
    logic [20:0]        n_du_mag;
    logic signed [12:0] n_q_s;
    logic signed [43:0] n_ms;
    logic [31:0]        n_rtt;

    assign n_full = (r_send_cnt == CNT_W'(TABLE_DEPTH));
    assign n_hlen = {i_ip_header_words, 2'b00};
    assign n_ilen = (i_packet_length >= 16'(n_hlen)) ? (i_packet_length - 16'(n_hlen)) : 16'd0;
    assign n_addr = i_action ? i_icmp_seq[SLOT_W-1:0] : r_send_cnt[SLOT_W-1:0];
    assign n_wr   = i_cmd.load && !i_action && !n_full;

    always_comb begin
        if (!i_action) begin
            n_status = n_full ? ST_FULL : ST_SENT;
        end else if (n_ilen < 16'(MIN_ICMP_LEN)) begin
            n_status = ST_SHORT;
        end else if (i_icmp_type != ECHO_REPLY_TYPE || i_icmp_ident != r_echo_ident) begin
            n_status = ST_NOT_OURS;
        end else if (32'(i_icmp_seq) >= 32'(TABLE_DEPTH)) begin
            n_status = ST_SEQ_RANGE;
        end else begin
            n_status = ST_ACCEPTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_ident <= '0;
            r_send_cnt   <= '0;
            r_rcv_cnt    <= '0;
            r_vld        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_echo_ident <= i_cfg_data;
            end
            if (n_wr) begin
                r_send_cnt      <= r_send_cnt + 1'b1;
                r_vld[n_addr]   <= 1'b1;
            end
            if (i_cmd.load && n_status == ST_ACCEPTED && r_rcv_cnt != RCV_MAX) begin
                r_rcv_cnt <= r_rcv_cnt + 16'd1;
            end
        end
    end

    // table port
    assign n_entry = {i_time_sec, i_time_usec};

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[n_addr] <= n_entry;
        end
        if (i_cmd.load) begin
            r_rd_data <= r_mem[n_addr];
            r_rd_vld  <= r_vld[n_addr];
        end
    end

    // difference with borrow
    always_comb begin
        logic [31:0] sent_s;
        logic [19:0] sent_us;
        sent_s  = r_rd_vld ? r_rd_data[ENTRY_W-1:USEC_W] : '0;
        sent_us = r_rd_vld ? r_rd_data[USEC_W-1:0] : '0;
        n_ds = $signed({1'b0, r_tsec}) - $signed({1'b0, sent_s});
        n_du = $signed({2'b00, r_tusec}) - $signed({2'b00, sent_us});
        if (n_du < 0) begin
            n_ds = n_ds - 33'sd1;
            n_du = n_du + 22'(USEC_PER_SEC);
        end
    end

    assign n_du_mag = r_du[21] ? 21'(-r_du) : 21'(r_du);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= n_status;
            r_seq    <= i_action ? i_icmp_seq : 16'(r_send_cnt);
            r_ilen   <= i_action ? n_ilen : 16'd0;
            r_tsec   <= i_time_sec;
            r_tusec  <= i_time_usec;
        end
        if (i_cmd.diff) begin
            r_ds <= n_ds;
            r_du <= n_du;
        end
        if (i_cmd.mul) begin
            r_ms_s   <= 43'(r_ds) * 43'(MS_PER_SEC);
            r_q      <= 42'(n_du_mag) * 42'(DIV_MUL);
            r_du_neg <= r_du[21];
        end
    end

    // sum and saturate
    always_comb begin
        logic [11:0] q;
        q     = r_q[DIV_SHIFT+11:DIV_SHIFT];
        n_q_s = r_du_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        n_ms  = 44'(r_ms_s) + 44'(n_q_s);
        if (n_ms < 0) begin
            n_rtt = '0;
        end else if (n_ms > $signed({12'd0, RTT_MAX})) begin
            n_rtt = RTT_MAX;
        end else begin
            n_rtt = n_ms[31:0];
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // counters are captured with the word, the next word may move them
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_seq    <= r_seq;
            r_out_rtt    <= (r_status == ST_ACCEPTED) ? n_rtt : '0;
            r_out_ilen   <= r_ilen;
            r_out_sent   <= 7'(r_send_cnt);
            r_out_rcvd   <= r_rcv_cnt;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_seq_number     = r_out_seq;
    assign o_rtt_ms         = r_out_rtt;
    assign o_icmp_length    = r_out_ilen;
    assign o_sent_total     = r_out_sent;
    assign o_received_total = r_out_rcvd;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_send_cnt <= CNT_W'(TABLE_DEPTH))
        else $error("send counter beyond table depth");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !i_out_ready))
        else $error("output register overwritten");

    a_rtt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_ACCEPTED |-> r_out_rtt == '0)
        else $error("rtt reported on rejected word");

    a_rcv_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load && n_status == ST_ACCEPTED |=>
            r_rcv_cnt != $past(r_rcv_cnt) || r_rcv_cnt == RCV_MAX)
        else $error("reply count not advanced");

    a_send_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load && n_status == ST_FULL |=> r_send_cnt == $past(r_send_cnt))
        else $error("send counter moved on full table");

endmodule

/* hw/rtl/echo_reply_rtt_tracker.sv */
// ----------------------------------------------------------------------------
// echo_reply_rtt_tracker
// Keeps send timestamps of echo requests and reports round trip time of
// matching echo replies.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    event fields
//   out      output     o_out_valid / i_out_ready  status, counts, rtt
//   cfg      input      i_cfg_valid / o_cfg_ready  echo identifier
//
// each word steps through table read, borrow subtract, multiply, sum
// the next word is accepted the cycle after its predecessor enters the output
// register, which holds one result while the sequencer returns to idle
// a stalled output holds the sequencer in its final step
// synchronous reset clears counters, valid bits and identifier; no sweep
// ----------------------------------------------------------------------------
module echo_reply_rtt_tracker
    import errt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [31:0] i_time_sec,
    input  logic [19:0] i_time_usec,
    input  logic [3:0]  i_ip_header_words,
    input  logic [15:0] i_packet_length,
    input  logic [7:0]  i_icmp_type,
    input  logic [15:0] i_icmp_ident,
    input  logic [15:0] i_icmp_seq,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_seq_number,
    output logic [31:0] o_rtt_ms,
    output logic [15:0] o_icmp_length,
    output logic [6:0]  o_sent_total,
    output logic [15:0] o_received_total
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    errt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    errt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_time_sec        (i_time_sec),
        .i_time_usec       (i_time_usec),
        .i_ip_header_words (i_ip_header_words),
        .i_packet_length   (i_packet_length),
        .i_icmp_type       (i_icmp_type),
        .i_icmp_ident      (i_icmp_ident),
        .i_icmp_seq        (i_icmp_seq),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_seq_number      (o_seq_number),
        .o_rtt_ms          (o_rtt_ms),
        .o_icmp_length     (o_icmp_length),
        .o_sent_total      (o_sent_total),
        .o_received_total  (o_received_total)
    );

endmodule

/* bench/echo_reply_rtt_tracker_test.sv */
// ----------------------------------------------------------------------------
// echo_reply_rtt_tracker_test
// Self-checking bench for the echo reply rtt tracker. Event words are queued
// by a stimulus sequence and handed to the block by a driver; every accepted
// word runs through a behavioural tracker that keeps its own send-time table
// and counters, and the monitor compares each result word with the oldest
// prediction. Covers directed corner cases, random traffic under several
// identifier settings, back-pressure and a closing stretch with no idling.
// ----------------------------------------------------------------------------
module echo_reply_rtt_tracker_test;

    timeunit 1ns;
    timeprecision 1ps;

    import errt_pkg::*;

    localparam int     RESET_CYCLES  = 9;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     LONG_HOLD     = 300;
    localparam int     QUIET_LIMIT   = 3000;
    localparam int     MAX_REPORTS   = 10;
    localparam longint RTT_CEILING   = 64'h0000_0000_ffff_ffff;

    typedef enum logic {
        EV_SEND    = 1'b0,
        EV_RECEIVE = 1'b1
    } t_action;

    typedef enum {
        GEN_SEND,
        GEN_REPLY,
        GEN_SHORT,
        GEN_FOREIGN,
        GEN_FAR_SEQ,
        GEN_NOISE
    } t_gen_kind;

    typedef struct packed {
        t_action     action;
        logic [31:0] time_sec;
        logic [19:0] time_usec;
        logic [3:0]  hwords;
        logic [15:0] plen;
        logic [7:0]  itype;
        logic [15:0] iident;
        logic [15:0] iseq;
    } t_event;

    typedef struct packed {
        t_status     status;
        logic [15:0] seq;
        logic [31:0] rtt;
        logic [15:0] icmp_len;
        logic [6:0]  sent;
        logic [15:0] rcvd;
    } t_result;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic [15:0] i_cfg_data        = '0;
    logic        i_in_valid        = 1'b0;
    logic        i_action          = 1'b0;
    logic [31:0] i_time_sec        = '0;
    logic [19:0] i_time_usec       = '0;
    logic [3:0]  i_ip_header_words = '0;
    logic [15:0] i_packet_length   = '0;
    logic [7:0]  i_icmp_type       = '0;
    logic [15:0] i_icmp_ident      = '0;
    logic [15:0] i_icmp_seq        = '0;
    logic        i_out_ready       = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [15:0] o_seq_number;
    logic [31:0] o_rtt_ms;
    logic [15:0] o_icmp_length;
    logic [6:0]  o_sent_total;
    logic [15:0] o_received_total;

    // tracker state
    logic [31:0] stamp_sec [TABLE_DEPTH]      = '{default: 32'd0};
    logic [19:0] stamp_usec [TABLE_DEPTH]     = '{default: 20'd0};
    logic        awaiting_reply [TABLE_DEPTH] = '{default: 1'b0};
    logic [6:0]  sent_count   = '0;
    logic [15:0] reply_count  = '0;
    logic [15:0] echo_ident_q = '0;

    t_event  pending_events[$];
    t_result expected_results[$];

    bit          idle_enabled  = 1'b1;
    bit          in_taken      = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned send_gap      = 0;
    int unsigned stall_left    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned words_in      = 0;
    int unsigned words_out     = 0;
    int unsigned ident_writes  = 0;
    int unsigned mismatches    = 0;
    int unsigned accepted_seen = 0;

    // stimulus side timestamp clock and send tally
    int unsigned now_sec  = 0;
    int unsigned now_usec = 0;
    int unsigned gen_sends = 0;

    echo_reply_rtt_tracker dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_action          (i_action),
        .i_time_sec        (i_time_sec),
        .i_time_usec       (i_time_usec),
        .i_ip_header_words (i_ip_header_words),
        .i_packet_length   (i_packet_length),
        .i_icmp_type       (i_icmp_type),
        .i_icmp_ident      (i_icmp_ident),
        .i_icmp_seq        (i_icmp_seq),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_seq_number      (o_seq_number),
        .o_rtt_ms          (o_rtt_ms),
        .o_icmp_length     (o_icmp_length),
        .o_sent_total      (o_sent_total),
        .o_received_total  (o_received_total)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] round_trip_ms(int unsigned slot, logic [31:0] now_s,
                                                  logic [19:0] now_us);
        longint d_sec;
        longint d_usec;
        longint ms;
        d_sec  = $signed({32'd0, now_s}) - $signed({32'd0, stamp_sec[slot]});
        d_usec = $signed({44'd0, now_us}) - $signed({44'd0, stamp_usec[slot]});
        if (d_usec < 0) begin
            d_sec  = d_sec - 1;
            d_usec = d_usec + USEC_PER_SEC;
        end
        // division truncates toward zero on a still negative remainder
        ms = d_sec * MS_PER_SEC + d_usec / USEC_PER_MS;
        if (ms < 0)
            return 32'd0;
        if (ms > RTT_CEILING)
            return RTT_MAX;
        return ms[31:0];
    endfunction

    function automatic t_result track_event(t_event ev);
        t_result     r;
        logic [15:0] hdr;
        r   = '0;
        hdr = 16'({ev.hwords, 2'b00});
        if (ev.action == EV_SEND) begin
            r.seq = 16'(sent_count);
            if (sent_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                stamp_sec[sent_count]      = ev.time_sec;
                stamp_usec[sent_count]     = ev.time_usec;
                awaiting_reply[sent_count] = 1'b1;
                sent_count                 = sent_count + 7'd1;
                r.status                   = ST_SENT;
            end
        end else begin
            r.icmp_len = (ev.plen >= hdr) ? ev.plen - hdr : 16'd0;
            r.seq      = ev.iseq;
            if (r.icmp_len < MIN_ICMP_LEN) begin
                r.status = ST_SHORT;
            end else if (ev.itype != ECHO_REPLY_TYPE || ev.iident != echo_ident_q) begin
                r.status = ST_NOT_OURS;
            end else if (ev.iseq >= TABLE_DEPTH) begin
                r.status = ST_SEQ_RANGE;
            end else begin
                awaiting_reply[ev.iseq] = 1'b0;
                r.rtt = round_trip_ms(ev.iseq, ev.time_sec, ev.time_usec);
                if (reply_count != RCV_MAX)
                    reply_count = reply_count + 16'd1;
                r.status = ST_ACCEPTED;
            end
        end
        r.sent = sent_count;
        r.rcvd = reply_count;
        return r;
    endfunction

    function automatic void queue_event(t_action act, logic [31:0] sec, logic [19:0] usec,
                                        logic [3:0] hw, logic [15:0] plen, logic [7:0] itype,
                                        logic [15:0] iident, logic [15:0] iseq);
        t_event ev;
        ev.action    = act;
        ev.time_sec  = sec;
        ev.time_usec = usec;
        ev.hwords    = hw;
        ev.plen      = plen;
        ev.itype     = itype;
        ev.iident    = iident;
        ev.iseq      = iseq;
        pending_events.push_back(ev);
    endfunction

    function automatic t_event make_event(t_gen_kind kind);
        t_event      ev;
        logic [15:0] hdr;
        int unsigned span;
        now_usec = now_usec + $urandom_range(0, 300000);
        if (now_usec >= USEC_PER_SEC) begin
            now_usec = now_usec - USEC_PER_SEC;
            now_sec  = now_sec + 1;
        end
        now_sec = now_sec + $urandom_range(0, 1);
        span = (gen_sends == 0 || gen_sends > TABLE_DEPTH) ? TABLE_DEPTH : gen_sends;
        ev.action    = EV_RECEIVE;
        ev.time_sec  = now_sec;
        ev.time_usec = now_usec[19:0];
        ev.hwords    = 4'($urandom_range(0, 15));
        hdr          = 16'({ev.hwords, 2'b00});
        ev.plen      = hdr + 16'($urandom_range(8, 120));
        ev.itype     = ECHO_REPLY_TYPE;
        ev.iident    = echo_ident_q;
        ev.iseq      = 16'($urandom_range(0, span - 1));
        case (kind)
            GEN_SEND: begin
                ev.action = EV_SEND;
                ev.plen   = 16'($urandom);
                ev.itype  = 8'($urandom);
                ev.iident = 16'($urandom);
                ev.iseq   = 16'($urandom);
                gen_sends++;
            end
            GEN_REPLY: begin
                if ($urandom_range(0, 7) == 0)
                    ev.plen = 16'($urandom_range(int'(hdr) + 8, 65535));
                if ($urandom_range(0, 9) == 0) begin
                    ev.time_sec  = $urandom;
                    ev.time_usec = 20'($urandom);
                end
            end
            GEN_SHORT: begin
                ev.plen = 16'($urandom_range(0, int'(hdr) + 7));
            end
            GEN_FOREIGN: begin
                if ($urandom_range(0, 1) == 0)
                    ev.itype = 8'($urandom_range(1, 255));
                else
                    ev.iident = echo_ident_q ^ 16'($urandom_range(1, 65535));
            end
            GEN_FAR_SEQ: begin
                if ($urandom_range(0, 1) == 0)
                    ev.iseq = 16'($urandom_range(TABLE_DEPTH, TABLE_DEPTH + 3));
                else
                    ev.iseq = 16'($urandom_range(TABLE_DEPTH, 65535));
            end
            default: begin
                ev.action    = t_action'($urandom_range(0, 1));
                ev.time_sec  = $urandom;
                ev.time_usec = 20'($urandom);
                ev.plen      = 16'($urandom);
                ev.itype     = 8'($urandom);
                ev.iident    = 16'($urandom);
                ev.iseq      = 16'($urandom);
                if (ev.action == EV_SEND)
                    gen_sends++;
            end
        endcase
        return ev;
    endfunction

    function automatic void queue_random(int unsigned count, int unsigned send_pct);
        int unsigned pick;
        t_gen_kind   kind;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < send_pct)
                kind = GEN_SEND;
            else if (pick < send_pct + (100 - send_pct) / 2)
                kind = GEN_REPLY;
            else
                kind = t_gen_kind'($urandom_range(GEN_SHORT, GEN_NOISE));
            pending_events.push_back(make_event(kind));
        end
    endfunction

    task automatic write_ident(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        echo_ident_q = value;
        ident_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (pending_events.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result word %0d, %s: expected %0h, got %0h",
                         words_out, name, want, got);
        end
    endtask

    // driver: accept at the rising edge, present the next word at the falling edge
    always @(posedge i_clk) begin
        t_event seen;
        if (i_in_valid && o_in_ready) begin
            seen.action    = t_action'(i_action);
            seen.time_sec  = i_time_sec;
            seen.time_usec = i_time_usec;
            seen.hwords    = i_ip_header_words;
            seen.plen      = i_packet_length;
            seen.itype     = i_icmp_type;
            seen.iident    = i_icmp_ident;
            seen.iseq      = i_icmp_seq;
            expected_results.push_back(track_event(seen));
            in_taken = 1'b1;
            words_in++;
        end
    end

    always @(negedge i_clk) begin
        t_event cur;
        if (in_taken || !i_in_valid) begin
            in_taken = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                cur = pending_events.pop_front();
                i_in_valid        <= 1'b1;
                i_action          <= cur.action;
                i_time_sec        <= cur.time_sec;
                i_time_usec       <= cur.time_usec;
                i_ip_header_words <= cur.hwords;
                i_packet_length   <= cur.plen;
                i_icmp_type       <= cur.itype;
                i_icmp_ident      <= cur.iident;
                i_icmp_seq        <= cur.iseq;
                if (idle_enabled && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 6);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (idle_enabled && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 6);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (o_out_valid && i_out_ready) begin
            words_out++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result word %0d arrived with nothing expected, status %0d",
                             words_out, o_status);
            end else begin
                want = expected_results.pop_front();
                if (want.status == ST_ACCEPTED)
                    accepted_seen++;
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("seq_number", 32'(want.seq), 32'(o_seq_number));
                check_field("rtt_ms", want.rtt, o_rtt_ms);
                check_field("icmp_length", 32'(want.icmp_len), 32'(o_icmp_length));
                check_field("sent_total", 32'(want.sent), 32'(o_sent_total));
                check_field("received_total", 32'(want.rcvd), 32'(o_received_total));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else if (i_rst_n) begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_results.size());
                $display("echo_reply_rtt_tracker_test failed");
                $finish;
            end
        end
    end

    initial begin
        now_sec  = $urandom_range(0, 32'h7fff_ffff);
        now_usec = $urandom_range(0, 999999);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset identifier, corner cases
        queue_event(EV_RECEIVE, 32'hffff_ffff, 20'd999999, 4'd5, 16'd84, 8'd0, 16'd0, 16'd0);
        queue_event(EV_RECEIVE, 32'd0, 20'd0, 4'd0, 16'd8, 8'd0, 16'd0, 16'd63);
        queue_event(EV_SEND, 32'd100, 20'd500000, 4'd0, 16'd0, 8'd0, 16'd0, 16'd0);
        queue_event(EV_SEND, 32'd100, 20'd999999, 4'hf, 16'hffff, 8'hff, 16'hffff, 16'hffff);
        queue_event(EV_RECEIVE, 32'd100, 20'd400000, 4'd5, 16'd28, 8'd0, 16'd0, 16'd0);
        queue_event(EV_RECEIVE, 32'd102, 20'd5000, 4'd5, 16'd28, 8'd0, 16'd0, 16'd1);
        queue_event(EV_RECEIVE, 32'd100, 20'hfffff, 4'd5, 16'd28, 8'd0, 16'd0, 16'd0);
        queue_event(EV_SEND, 32'd200, 20'hfffff, 4'd0, 16'd0, 8'd0, 16'd0, 16'd0);
        queue_event(EV_RECEIVE, 32'd201, 20'd0, 4'd5, 16'd28, 8'd0, 16'd0, 16'd2);
        queue_event(EV_RECEIVE, 32'd203, 20'd0, 4'd5, 16'd28, 8'd0, 16'd0, 16'd2);
        queue_event(EV_RECEIVE, 32'd300, 20'd0, 4'hf, 16'd59, 8'd0, 16'd0, 16'd1);
        queue_event(EV_RECEIVE, 32'd300, 20'd0, 4'hf, 16'd67, 8'd0, 16'd0, 16'd1);
        queue_event(EV_RECEIVE, 32'd300, 20'd0, 4'hf, 16'd68, 8'd8, 16'd0, 16'd1);
        queue_event(EV_RECEIVE, 32'd300, 20'd0, 4'd5, 16'd64, 8'd0, 16'd1, 16'd1);
        queue_event(EV_RECEIVE, 32'd300, 20'd0, 4'd5, 16'd64, 8'd0, 16'd0, 16'd64);
        queue_event(EV_RECEIVE, 32'd300, 20'd0, 4'd5, 16'd64, 8'd0, 16'd0, 16'hffff);
        queue_event(EV_RECEIVE, 32'hffff_ffff, 20'd0, 4'd0, 16'hffff, 8'd0, 16'd0, 16'd1);
        queue_event(EV_RECEIVE, 32'hffff_ffff, 20'hfffff, 4'hf, 16'hffff, 8'hff, 16'hffff,
                    16'hffff);
        queue_event(EV_SEND, 32'd0, 20'd0, 4'd0, 16'd0, 8'd0, 16'd0, 16'd0);
        queue_event(EV_RECEIVE, 32'd0, 20'd999, 4'd5, 16'd28, 8'd0, 16'd0, 16'd3);
        queue_event(EV_RECEIVE, 32'd0, 20'd1000, 4'd5, 16'd28, 8'd0, 16'd0, 16'd3);
        queue_event(EV_RECEIVE, 32'd0, 20'd999999, 4'd5, 16'd28, 8'd0, 16'd0, 16'd3);
        gen_sends = 4;
        wait_until_drained();

        // send-heavy traffic fills the table; a long receiver hold backs up the input
        write_ident(16'hffff);
        queue_random(300, 40);
        while (pending_events.size() > 200)
            @(posedge i_clk);
        long_hold_req = 1'b1;
        wait_until_drained();

        write_ident(16'($urandom_range(1, 16'hfffe)));
        queue_random(300, 15);
        wait_until_drained();

        // closing stretch back to back with no idling on either side
        write_ident(16'h0000);
        idle_enabled = 1'b0;
        queue_random(300, 15);
        wait_until_drained();

        $display("covered %0d event words and %0d result words over %0d identifier settings",
                 words_in, words_out, ident_writes + 1);
        $display("table filled to %0d slots, %0d replies accepted, reply count ended at %0h",
                 sent_count, accepted_seen, reply_count);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("echo_reply_rtt_tracker_test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("echo_reply_rtt_tracker_test failed");
        end
        $finish;
    end

endmodule

/* echo_reply_rtt_tracker.f */
hw/rtl/errt_pkg.sv
hw/rtl/errt_ctrl.sv
hw/rtl/errt_dp.sv
hw/rtl/echo_reply_rtt_tracker.sv
bench/echo_reply_rtt_tracker_test.sv
